@@ design/rqst_pkg.sv @@
// Package for the range query segment tree: sizes, codes, shared types and the
// identity function. Used by every module of the block; depends on nothing.
`default_nettype none

package rqst_pkg;

  localparam int LEAVES   = 1024;
  localparam int VALUE_W  = 32;
  localparam int SPAN     = 1 << $clog2(LEAVES);
  localparam int NODES    = 2 * SPAN;
  localparam int NODE_AW  = $clog2(NODES);
  localparam int IDX_W    = NODE_AW + 1;
  localparam int POS_W    = 10;
  localparam int BOUND_W  = 11;
  localparam int MODE_W   = 2;
  localparam int ANSWER_W = 32;

  localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUM = 2'd2;

  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [NODE_AW-1:0] node_addr_t;
  typedef logic [IDX_W-1:0]   node_idx_t;
  typedef logic [MODE_W-1:0]  mode_t;

  localparam node_addr_t NODE_ROOT = node_addr_t'(1);
  localparam node_addr_t NODE_LAST = node_addr_t'(NODES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP_RD,
    ST_UP_WR,
    ST_Q_LEFT,
    ST_Q_LWAIT,
    ST_Q_RIGHT,
    ST_Q_RWAIT,
    ST_Q_SHIFT,
    ST_Q_DONE
  } state_t;

  typedef struct packed {
    logic       we;
    node_addr_t waddr;
    value_t     wdata;
    logic       re;
    node_addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic   valid;
    value_t data;
  } result_t;

  function automatic value_t identity(mode_t mode);
    value_t id;
    case (mode)
      MODE_MIN: id = {1'b0, {(VALUE_W-1){1'b1}}};
      MODE_MAX: id = {1'b1, {(VALUE_W-1){1'b0}}};
      default:  id = '0;
    endcase
    return id;
  endfunction

endpackage

`default_nettype wire

@@ design/rqst_tree_mem.sv @@
// Node memory of the segment tree: one write port and one registered read port.
// Uses rqst_pkg for the node address and request types.
`default_nettype none

module rqst_tree_mem (
  input  wire logic              clk,
  input  wire rqst_pkg::mem_req_t req,
  output rqst_pkg::value_t        rdata
);
  import rqst_pkg::*;

  value_t mem [0:NODES-1];
  value_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/rqst_alu.sv @@
// Shared combine unit: signed minimum, signed maximum or wrapping sum.
// Uses rqst_pkg for the value type and mode codes.
`default_nettype none

module rqst_alu (
  input  wire rqst_pkg::mode_t  mode,
  input  wire rqst_pkg::value_t a,
  input  wire rqst_pkg::value_t b,
  output rqst_pkg::value_t      y
);
  import rqst_pkg::*;

  logic a_lt_b;

  assign a_lt_b = $signed(a) < $signed(b);

  always_comb begin
    case (mode)
      MODE_MIN: y = a_lt_b ? a : b;
      MODE_MAX: y = a_lt_b ? b : a;
      default:  y = a + b;
    endcase
  end

endmodule

`default_nettype wire

@@ design/rqst_seq.sv @@
// Sequencer of the segment tree: clearing pass, leaf update walk and range
// query walk, driving the node memory and the shared combine unit.
// Uses rqst_pkg for sizes, codes, the state type and the request structs.
`default_nettype none

module rqst_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_fire,
  input  wire logic                          in_func,
  input  wire logic [rqst_pkg::POS_W-1:0]    in_position,
  input  wire rqst_pkg::value_t              in_value,
  input  wire logic [rqst_pkg::BOUND_W-1:0]  in_range_lo,
  input  wire logic [rqst_pkg::BOUND_W-1:0]  in_range_hi,
  output logic                               in_idle,
  input  wire logic                          cfg_fire,
  input  wire rqst_pkg::mode_t               cfg_mode,
  output rqst_pkg::mem_req_t                 mem_req,
  input  wire rqst_pkg::value_t              mem_rdata,
  output rqst_pkg::mode_t                    alu_mode,
  output rqst_pkg::value_t                   alu_a,
  input  wire rqst_pkg::value_t              alu_y,
  output rqst_pkg::result_t                  res,
  input  wire logic                          out_free
);
  import rqst_pkg::*;

  localparam logic [BOUND_W-1:0] BOUND_MAX = BOUND_W'(LEAVES);

  state_t     state_r, state_nxt;
  mode_t      mode_r, mode_nxt;
  node_addr_t clr_r, clr_nxt;
  node_addr_t k_r, k_nxt;
  node_idx_t  l_r, l_nxt;
  node_idx_t  r_r, r_nxt;
  value_t     acc_r, acc_nxt;

  logic [BOUND_W-1:0] lo_c, hi_c;
  logic               pos_ok;
  node_addr_t         leaf_addr;
  node_idx_t          r_dec;

  assign lo_c      = (in_range_lo > BOUND_MAX) ? BOUND_MAX : in_range_lo;
  assign hi_c      = (in_range_hi > BOUND_MAX) ? BOUND_MAX : in_range_hi;
  assign pos_ok    = {1'b0, in_position} < (POS_W+1)'(LEAVES);
  assign leaf_addr = node_addr_t'(SPAN) + node_addr_t'(in_position);
  assign r_dec     = r_r - node_idx_t'(1);

  assign in_idle  = (state_r == ST_IDLE);
  assign alu_mode = mode_r;
  assign alu_a    = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      mode_r  <= MODE_MIN;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    l_r   <= l_nxt;
    r_r   <= r_nxt;
    acc_r <= acc_nxt;
  end

  // Next state. A mode write restarts the clearing pass from any state.
  always_comb begin
    state_nxt = state_r;
    if (cfg_fire) begin
      state_nxt = ST_CLEAR;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (clr_r == NODE_LAST) state_nxt = ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire) begin
            if (in_func == FUNC_SET) begin
              if (pos_ok) state_nxt = ST_UP_RD;
            end else if (lo_c < hi_c) begin
              state_nxt = ST_Q_LEFT;
            end else begin
              state_nxt = ST_Q_DONE;
            end
          end
        end
        ST_UP_RD:   state_nxt = (k_r == NODE_ROOT) ? ST_IDLE : ST_UP_WR;
        ST_UP_WR:   state_nxt = ST_UP_RD;
        ST_Q_LEFT: begin
          if (!(l_r < r_r))  state_nxt = ST_Q_DONE;
          else if (l_r[0])   state_nxt = ST_Q_LWAIT;
          else               state_nxt = ST_Q_RIGHT;
        end
        ST_Q_LWAIT: state_nxt = ST_Q_RIGHT;
        ST_Q_RIGHT: state_nxt = r_r[0] ? ST_Q_RWAIT : ST_Q_SHIFT;
        ST_Q_RWAIT: state_nxt = ST_Q_SHIFT;
        ST_Q_SHIFT: state_nxt = ST_Q_LEFT;
        ST_Q_DONE: begin
          if (out_free) state_nxt = ST_IDLE;
        end
        default:    state_nxt = ST_CLEAR;
      endcase
    end
  end

  // Memory requests and datapath updates.
  always_comb begin
    mem_req   = '0;
    mode_nxt  = cfg_fire ? cfg_mode : mode_r;
    clr_nxt   = clr_r;
    k_nxt     = k_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    acc_nxt   = acc_r;
    res.valid = 1'b0;
    res.data  = acc_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = identity(mode_r);
        clr_nxt       = clr_r + node_addr_t'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_SET) begin
            mem_req.we    = pos_ok;
            mem_req.waddr = leaf_addr;
            mem_req.wdata = in_value;
            acc_nxt       = in_value;
            k_nxt         = leaf_addr;
          end else begin
            acc_nxt = identity(mode_r);
            l_nxt   = node_idx_t'(SPAN) + node_idx_t'(lo_c);
            r_nxt   = node_idx_t'(SPAN) + node_idx_t'(hi_c);
          end
        end
      end
      ST_UP_RD: begin
        // Fetch the sibling; acc_r holds the node just written.
        mem_req.re    = (k_r != NODE_ROOT);
        mem_req.raddr = k_r ^ node_addr_t'(1);
      end
      ST_UP_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = k_r >> 1;
        mem_req.wdata = alu_y;
        acc_nxt       = alu_y;
        k_nxt         = k_r >> 1;
      end
      ST_Q_LEFT: begin
        mem_req.re    = (l_r < r_r) && l_r[0];
        mem_req.raddr = l_r[NODE_AW-1:0];
      end
      ST_Q_LWAIT: begin
        acc_nxt = alu_y;
        l_nxt   = l_r + node_idx_t'(1);
      end
      ST_Q_RIGHT: begin
        mem_req.re    = r_r[0];
        mem_req.raddr = r_dec[NODE_AW-1:0];
        if (r_r[0]) r_nxt = r_dec;
      end
      ST_Q_RWAIT: begin
        acc_nxt = alu_y;
      end
      ST_Q_SHIFT: begin
        l_nxt = l_r >> 1;
        r_nxt = r_r >> 1;
      end
      ST_Q_DONE: begin
        res.valid = 1'b1;
      end
      default: begin
        mem_req = '0;
      end
    endcase
    if (cfg_fire) clr_nxt = '0;
  end

endmodule

`default_nettype wire

@@ design/range_query_segment_tree_top.sv @@
// Segment tree over 1024 signed 32-bit leaves with min, max or sum combining.
// A set reads each sibling and writes each parent up to the root; a query folds
// in the odd end nodes of each level. Both are bound by the single read port of
// the node memory and the one shared combine unit; one request is in work at a
// time. After reset and every mode write, a clearing pass fills the tree with
// the mode's identity; no request is accepted during it.
`default_nettype none

module range_query_segment_tree_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // position[9:0], value[41:10], range_lo[52:42], range_hi[63:53]
  input  wire logic [63:0] in_tdata,
  // func[0]
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // answer[31:0]
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data
);
  import rqst_pkg::*;

  logic     in_idle, in_fire, cfg_fire, out_free;
  mem_req_t mem_req;
  value_t   mem_rdata;
  mode_t    alu_mode;
  value_t   alu_a, alu_y;
  result_t  res;

  logic   out_valid_r, out_valid_nxt;
  value_t out_data_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_tready = in_idle & ~cfg_valid;
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  rqst_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_func     (in_tuser[0]),
    .in_position (in_tdata[9:0]),
    .in_value    (in_tdata[41:10]),
    .in_range_lo (in_tdata[52:42]),
    .in_range_hi (in_tdata[63:53]),
    .in_idle     (in_idle),
    .cfg_fire    (cfg_fire),
    .cfg_mode    (cfg_data),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .alu_mode    (alu_mode),
    .alu_a       (alu_a),
    .alu_y       (alu_y),
    .res         (res),
    .out_free    (out_free)
  );

  rqst_tree_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  rqst_alu u_alu (
    .mode (alu_mode),
    .a    (alu_a),
    .b    (mem_rdata),
    .y    (alu_y)
  );

  // Output register: lets the next request start while an answer waits.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      out_data_r <= res.data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r[ANSWER_W-1:0];

endmodule

`default_nettype wire
